>>> sv/pfs_pkg.sv
// ---------------------------------------------------------------------------
// Page free stack package
// Shared constants, codes and types of the two-level page allocator.
// ---------------------------------------------------------------------------
package pfs_pkg;

    localparam int PAGE_BITS_DEF   = 16;
    localparam int LOCAL_DEPTH_DEF = 32;

    localparam int PAGE_W   = 16;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 6;
    localparam int CNT_W    = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(25);
    localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_SEED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_KEPT = 2'd2;

    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_INC,
        ALU_DEC,
        ALU_INC_SAT
    } alu_op_t;

    typedef struct packed {
        logic lt;
        logic zero;
    } alu_flags_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_R_CMP,
        ST_R_DEC,
        ST_R_WR,
        ST_A_POP,
        ST_A_GOT,
        ST_A_INC,
        ST_F_RD,
        ST_F_DEC,
        ST_F_CMP,
        ST_F_LINC,
        ST_F_GINC,
        ST_RESP
    } state_t;

endpackage

>>> sv/pfs_if.sv
// ---------------------------------------------------------------------------
// Page free stack channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pfs_req_if;
    import pfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;

    modport source (output valid, output mode, output page, input ready);
    modport sink   (input valid, input mode, input page, output ready);
endinterface

interface pfs_rsp_if;
    import pfs_pkg::*;

    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   alloc_page;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output alloc_page, output status, input ready);
    modport sink   (input valid, input alloc_page, input status, output ready);
endinterface

>>> sv/pfs_ram.sv
// ---------------------------------------------------------------------------
// Page free stack RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module pfs_ram #(
    parameter int              WIDTH = 16,
    parameter longint unsigned DEPTH = 32
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pfs_alu.sv
// ---------------------------------------------------------------------------
// Page free stack arithmetic unit
// Shared increment, decrement, saturating increment and compare.
// ---------------------------------------------------------------------------
module pfs_alu #(
    parameter int W = 17
) (
    input  pfs_pkg::alu_op_t    op,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic [W-1:0]        res,
    output pfs_pkg::alu_flags_t flags
);
    import pfs_pkg::*;

    logic [W-1:0] inc_val;
    logic [W-1:0] dec_val;

    assign inc_val = a + W'(1);
    assign dec_val = a - W'(1);

    always_comb
    begin
        case (op)
            ALU_INC:     res = inc_val;
            ALU_DEC:     res = dec_val;
            // Holds at the ceiling given on b.
            ALU_INC_SAT: res = (a == b) ? a : inc_val;
            ALU_CMP:     res = a;
            default:     res = a;
        endcase
    end

    assign flags.lt   = (a < b);
    assign flags.zero = (res == '0);

endmodule

>>> sv/two_level_page_free_stack.sv
// ---------------------------------------------------------------------------
// Two-level page free stack
// Page allocator with a global LIFO pool and one local LIFO cache.
// ---------------------------------------------------------------------------
// Usage: a request beat on req carries mode (seed, allocate, free) and page.
// Each request gives exactly one response beat on rsp with alloc_page and
// status. The limit register is written through cfg_we/cfg_wdata; the user
// is to write it only while idle, which the block itself does not enforce.
// Requests are taken one at a time; req.ready is high only in the idle state.
// An allocate from an empty cache first refills it from the global pool, up
// to the limit (25 after reset). The refill loop is set by the single global
// pool port and the shared arithmetic unit: each page moved takes a compare,
// a pointer decrement with read, and a write with increment.
// The response sits in an output register, so a new request is accepted
// while an earlier response waits on a stalled receiver; the next response
// then holds in its final state until the register frees up.
// Reset clears both pool counts and sets the limit to 25; pool and count
// memories are not cleared and hold data only once written.
// ---------------------------------------------------------------------------
module two_level_page_free_stack #(
    parameter int PAGE_BITS   = pfs_pkg::PAGE_BITS_DEF,
    parameter int LOCAL_DEPTH = pfs_pkg::LOCAL_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pfs_pkg::LIMIT_W-1:0] cfg_wdata,
    pfs_req_if.sink                     req,
    pfs_rsp_if.source                   rsp
);
    import pfs_pkg::*;

    localparam longint unsigned POOL_DEPTH = 64'd1 << PAGE_BITS;
    localparam int GC_W = PAGE_BITS + 1;
    localparam int LC_W = $clog2(LOCAL_DEPTH + 1);
    localparam int LA_W = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
    localparam int AW   = (GC_W > CNT_W) ? GC_W : CNT_W;
    localparam logic [PAGE_W-1:0] PAGE_MASK =
        (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

    state_t state_reg, state_next;

    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [GC_W-1:0]     gcnt_reg, gcnt_next;
    logic [LC_W-1:0]     lcnt_reg, lcnt_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [PAGE_W-1:0]   out_page_reg, out_page_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [LC_W-1:0] eff_limit;
    logic            gpool_full;

    alu_op_t    alu_op;
    logic [AW-1:0] alu_a, alu_b, alu_res;
    alu_flags_t alu_flags;

    logic                 g_we, l_we, r_we;
    logic [PAGE_BITS-1:0] g_waddr, g_raddr, r_waddr, r_raddr;
    logic [LA_W-1:0]      l_waddr, l_raddr;
    logic [PAGE_W-1:0]    g_wdata, g_rdata, l_wdata, l_rdata;
    logic [CNT_W-1:0]     r_wdata, r_rdata;

    pfs_alu #(.W(AW)) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    pfs_ram #(.WIDTH(PAGE_W), .DEPTH(POOL_DEPTH)) u_global_pool (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    pfs_ram #(.WIDTH(PAGE_W), .DEPTH(LOCAL_DEPTH)) u_local_pool (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    pfs_ram #(.WIDTH(CNT_W), .DEPTH(POOL_DEPTH)) u_ref_counts (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign eff_limit  = (32'(limit_reg) < LOCAL_DEPTH) ? LC_W'(limit_reg)
                                                       : LC_W'(LOCAL_DEPTH);
    assign gpool_full = gcnt_reg[PAGE_BITS];

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.alloc_page = out_page_reg;
    assign rsp.status     = out_status_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.mode)
                        MODE_SEED:  state_next = ST_SEED;
                        MODE_ALLOC: state_next = (lcnt_reg == '0) ? ST_R_CMP : ST_A_POP;
                        MODE_FREE:  state_next = ST_F_RD;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_SEED:   state_next = ST_RESP;
            ST_R_CMP:  state_next = (alu_flags.lt && gcnt_reg != '0) ? ST_R_DEC : ST_A_POP;
            ST_R_DEC:  state_next = ST_R_WR;
            ST_R_WR:   state_next = ST_R_CMP;
            ST_A_POP:  state_next = (lcnt_reg == '0) ? ST_RESP : ST_A_GOT;
            ST_A_GOT:  state_next = ST_A_INC;
            ST_A_INC:  state_next = ST_RESP;
            ST_F_RD:   state_next = ST_F_DEC;
            ST_F_DEC:
            begin
                if (r_rdata == '0 || !alu_flags.zero)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_F_CMP;
                end
            end
            ST_F_CMP:
            begin
                if (alu_flags.lt)
                begin
                    state_next = ST_F_LINC;
                end
                else if (!gpool_full)
                begin
                    state_next = ST_F_GINC;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_F_LINC: state_next = ST_RESP;
            ST_F_GINC: state_next = ST_RESP;
            ST_RESP:   state_next = (!out_valid_reg || rsp.ready) ? ST_IDLE : ST_RESP;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        page_next       = page_reg;
        gcnt_next       = gcnt_reg;
        lcnt_next       = lcnt_reg;
        limit_next      = cfg_we ? cfg_wdata : limit_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;

        alu_op = ALU_CMP;
        alu_a  = '0;
        alu_b  = '0;

        g_we    = 1'b0;
        g_waddr = gcnt_reg[PAGE_BITS-1:0];
        g_wdata = page_reg;
        g_raddr = alu_res[PAGE_BITS-1:0];
        l_we    = 1'b0;
        l_waddr = lcnt_reg[LA_W-1:0];
        l_wdata = page_reg;
        l_raddr = alu_res[LA_W-1:0];
        r_we    = 1'b0;
        r_waddr = PAGE_BITS'(page_reg);
        r_wdata = alu_res[CNT_W-1:0];
        r_raddr = PAGE_BITS'(page_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    page_next       = req.page & PAGE_MASK;
                    res_page_next   = '0;
                    res_status_next = STAT_OK;
                end
            end
            ST_SEED:
            begin
                r_we    = 1'b1;
                r_wdata = '0;
                alu_op  = ALU_INC;
                alu_a   = AW'(gcnt_reg);
                if (!gpool_full)
                begin
                    g_we      = 1'b1;
                    gcnt_next = alu_res[GC_W-1:0];
                end
            end
            ST_R_CMP:
            begin
                alu_a = AW'(lcnt_reg);
                alu_b = AW'(eff_limit);
            end
            ST_R_DEC:
            begin
                // The decremented count is the address of the top entry.
                alu_op    = ALU_DEC;
                alu_a     = AW'(gcnt_reg);
                gcnt_next = alu_res[GC_W-1:0];
            end
            ST_R_WR:
            begin
                l_we      = 1'b1;
                l_wdata   = g_rdata;
                alu_op    = ALU_INC;
                alu_a     = AW'(lcnt_reg);
                lcnt_next = alu_res[LC_W-1:0];
            end
            ST_A_POP:
            begin
                if (lcnt_reg == '0)
                begin
                    res_status_next = STAT_OOM;
                end
                else
                begin
                    alu_op    = ALU_DEC;
                    alu_a     = AW'(lcnt_reg);
                    lcnt_next = alu_res[LC_W-1:0];
                end
            end
            ST_A_GOT:
            begin
                page_next     = l_rdata;
                res_page_next = l_rdata;
                r_raddr       = PAGE_BITS'(l_rdata);
            end
            ST_A_INC:
            begin
                alu_op = ALU_INC_SAT;
                alu_a  = AW'(r_rdata);
                alu_b  = AW'(COUNT_MAX);
                r_we   = 1'b1;
            end
            ST_F_DEC:
            begin
                if (r_rdata == '0)
                begin
                    // A free of a page with no references is a double free.
                    res_status_next = STAT_KEPT;
                end
                else
                begin
                    alu_op = ALU_DEC;
                    alu_a  = AW'(r_rdata);
                    r_we   = 1'b1;
                    if (!alu_flags.zero)
                    begin
                        res_status_next = STAT_KEPT;
                    end
                end
            end
            ST_F_CMP:
            begin
                alu_a = AW'(lcnt_reg);
                alu_b = AW'(eff_limit);
                if (alu_flags.lt)
                begin
                    l_we = 1'b1;
                end
                else if (!gpool_full)
                begin
                    g_we = 1'b1;
                end
            end
            ST_F_LINC:
            begin
                alu_op    = ALU_INC;
                alu_a     = AW'(lcnt_reg);
                lcnt_next = alu_res[LC_W-1:0];
            end
            ST_F_GINC:
            begin
                alu_op    = ALU_INC;
                alu_a     = AW'(gcnt_reg);
                gcnt_next = alu_res[GC_W-1:0];
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = res_page_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gcnt_reg       <= '0;
            lcnt_reg       <= '0;
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gcnt_reg       <= gcnt_next;
            lcnt_reg       <= lcnt_next;
            limit_reg      <= limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    a_lcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lcnt_reg <= LC_W'(LOCAL_DEPTH))
        else $error("local cache count exceeds its depth");

    a_gcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(gcnt_reg[PAGE_BITS] && gcnt_reg[PAGE_BITS-1:0] != '0))
        else $error("global pool count exceeds the pool size");

    a_refill_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_R_CMP || state_reg == ST_R_DEC || state_reg == ST_R_WR)
        |-> lcnt_reg <= eff_limit)
        else $error("refill moved more pages than the limit");

    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_OK) |-> rsp.alloc_page == '0)
        else $error("failed or kept response carries a page number");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != ST_IDLE)
        else $error("request beat accepted without leaving idle");

endmodule
